FILE: hw/rtl/waveform_batch_statistics_macros.svh
// ----------------------------------------------------------------------------
// waveform batch statistics assertion macros
// shared concurrent assertion forms for the checker
// ----------------------------------------------------------------------------
`ifndef WAVEFORM_BATCH_STATISTICS_MACROS_SVH
`define WAVEFORM_BATCH_STATISTICS_MACROS_SVH

// same-cycle implication, off during reset
`define WBS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wbs assertion failed");

// next-cycle implication, off during reset
`define WBS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wbs assertion failed");

// state in the cycle after reset is applied
`define WBS_ASSERT_RESET(lbl, clk, rst_n, cons) \
    lbl: assert property (@(posedge clk) (!rst_n) |=> (cons)) \
        else $error("wbs reset assertion failed");

`endif

FILE: hw/rtl/wbs_pkg.sv
// ----------------------------------------------------------------------------
// wbs_pkg
// widths, register codes and control types of the batch statistics block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package wbs_pkg;

    localparam int SAMPLE_BITS = 12;
    localparam int HALF_W      = SAMPLE_BITS - 1;
    localparam int SQR_W       = 2 * SAMPLE_BITS;
    localparam int SUM_W       = 32;
    localparam int SQ_W        = 48;
    localparam int CNT_W       = 21;
    localparam int LEN_W       = 21;
    localparam int DIVR_W      = 2 * HALF_W;
    localparam int RATIO_W     = 16;
    localparam int TARGET_W    = 16;
    localparam int CFG_W       = 21;
    localparam int CFG_IDX_W   = 3;

    // ratio scale 1000 = 1024 - 16 - 8
    localparam int SCALE_SHIFT = 10;
    localparam int SCALE_SUB_A = 4;
    localparam int SCALE_SUB_B = 3;
    localparam int SCALED_W    = SQ_W + SCALE_SHIFT;

    // shared divider
    localparam int DVD_W  = SCALED_W;
    localparam int DVS_W  = (LEN_W > DIVR_W) ? LEN_W : DIVR_W;
    localparam int STEP_W = $clog2(DVD_W);

    localparam logic [LEN_W-1:0]    MAX_BATCH_LEN   = LEN_W'(1048576);
    localparam logic [LEN_W-1:0]    RST_BATCH_LEN   = LEN_W'(100000);
    localparam logic [TARGET_W-1:0] RST_MARGIN      = TARGET_W'(75);
    localparam logic [TARGET_W-1:0] RST_TRI_TARGET  = TARGET_W'(333);
    localparam logic [TARGET_W-1:0] RST_SINE_TARGET = TARGET_W'(500);
    localparam logic [TARGET_W-1:0] RST_RECT_TARGET = TARGET_W'(1000);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BATCH_LEN    = 3'd0,
        REG_CLASS_MARGIN = 3'd1,
        REG_TRI_TARGET   = 3'd2,
        REG_SINE_TARGET  = 3'd3,
        REG_RECT_TARGET  = 3'd4
    } t_cfg_reg;

    typedef enum logic [1:0] {
        CLS_NONE     = 2'd0,
        CLS_TRIANGLE = 2'd1,
        CLS_SINE     = 2'd2,
        CLS_RECT     = 2'd3
    } t_shape_class;

    typedef enum logic [1:0] {
        DSEL_MEAN  = 2'd0,
        DSEL_MSQ   = 2'd1,
        DSEL_RATIO = 2'd2
    } t_div_sel;

    typedef struct packed {
        logic     accum;
        logic     div_start;
        t_div_sel div_sel;
        logic     scale_hi;
        logic     scale_lo;
        logic     out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic batch_end;
        logic div_done;
        logic flat;
    } t_dp_sts;

endpackage

`default_nettype wire

FILE: hw/rtl/wbs_sample_if.sv
// ----------------------------------------------------------------------------
// wbs_sample_if
// sample channel: valid, ready and one converter reading
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface wbs_sample_if;

    logic                             valid;
    logic                             ready;
    logic [wbs_pkg::SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);

endinterface

`default_nettype wire

FILE: hw/rtl/wbs_result_if.sv
// ----------------------------------------------------------------------------
// wbs_result_if
// result channel: valid, ready and the statistics of one batch
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface wbs_result_if;

    logic                             valid;
    logic                             ready;
    logic [wbs_pkg::SAMPLE_BITS-1:0] batch_min;
    logic [wbs_pkg::SAMPLE_BITS-1:0] batch_max;
    logic [wbs_pkg::SAMPLE_BITS-1:0] batch_mean;
    logic [wbs_pkg::RATIO_W-1:0]     shape_ratio;
    wbs_pkg::t_shape_class            shape_class;
    logic                             flat_signal;

    modport source (
        output valid, output batch_min, output batch_max, output batch_mean,
        output shape_ratio, output shape_class, output flat_signal,
        input ready
    );
    modport sink (
        input valid, input batch_min, input batch_max, input batch_mean,
        input shape_ratio, input shape_class, input flat_signal,
        output ready
    );

endinterface

`default_nettype wire

FILE: hw/rtl/wbs_ctrl.sv
// ----------------------------------------------------------------------------
// wbs_ctrl
// sequencer: accumulation, end-of-batch divisions and result hand-off
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wbs_ctrl (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  wire               i_out_ready,
    output wbs_pkg::t_dp_cmd  o_cmd,
    input  wbs_pkg::t_dp_sts  i_sts
);

    typedef enum logic [3:0] {
        S_ACCUM,
        S_MEAN_GO,
        S_MEAN_WAIT,
        S_MSQ_GO,
        S_MSQ_WAIT,
        S_SCALE_HI,
        S_SCALE_LO,
        S_RATIO_GO,
        S_RATIO_WAIT,
        S_EMIT
    } t_state;

    t_state r_state;
    logic   r_in_ready;
    logic   r_out_valid;
    logic   accept;
    logic   out_free;

    assign accept      = i_in_valid && r_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = r_in_ready;
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd           = '0;
        o_cmd.div_sel   = wbs_pkg::DSEL_MEAN;
        o_cmd.accum     = accept;
        o_cmd.scale_hi  = (r_state == S_SCALE_HI);
        o_cmd.scale_lo  = (r_state == S_SCALE_LO);
        o_cmd.out_load  = (r_state == S_EMIT) && out_free;
        unique case (r_state)
            S_MEAN_GO: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = wbs_pkg::DSEL_MEAN;
            end
            S_MSQ_GO: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = wbs_pkg::DSEL_MSQ;
            end
            S_RATIO_GO: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = wbs_pkg::DSEL_RATIO;
            end
            default: begin
                o_cmd.div_start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_ACCUM;
            r_in_ready  <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            // in the emit state a freed register is refilled below
            if (r_out_valid && i_out_ready && (r_state != S_EMIT)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_ACCUM: begin
                    if (accept && i_sts.batch_end) begin
                        r_state    <= S_MEAN_GO;
                        r_in_ready <= 1'b0;
                    end
                end
                S_MEAN_GO:  r_state <= S_MEAN_WAIT;
                S_MEAN_WAIT: begin
                    if (i_sts.div_done) begin
                        r_state <= S_MSQ_GO;
                    end
                end
                S_MSQ_GO:   r_state <= S_MSQ_WAIT;
                S_MSQ_WAIT: begin
                    if (i_sts.div_done) begin
                        r_state <= i_sts.flat ? S_EMIT : S_SCALE_HI;
                    end
                end
                S_SCALE_HI: r_state <= S_SCALE_LO;
                S_SCALE_LO: r_state <= S_RATIO_GO;
                S_RATIO_GO: r_state <= S_RATIO_WAIT;
                S_RATIO_WAIT: begin
                    if (i_sts.div_done) begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_in_ready  <= 1'b1;
                        r_state     <= S_ACCUM;
                    end
                end
                default: begin
                    r_state    <= S_ACCUM;
                    r_in_ready <= 1'b1;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/wbs_dpath.sv
// ----------------------------------------------------------------------------
// wbs_dpath
// config registers, accumulators, shared restoring divider, result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wbs_dpath (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wbs_pkg::t_dp_cmd                   i_cmd,
    output wbs_pkg::t_dp_sts                   o_sts,
    input  wire [wbs_pkg::SAMPLE_BITS-1:0]     i_sample,
    input  wire                                i_cfg_we,
    input  wire [wbs_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  wire [wbs_pkg::CFG_W-1:0]           i_cfg_wdata,
    output logic [wbs_pkg::SAMPLE_BITS-1:0]    o_batch_min,
    output logic [wbs_pkg::SAMPLE_BITS-1:0]    o_batch_max,
    output logic [wbs_pkg::SAMPLE_BITS-1:0]    o_batch_mean,
    output logic [wbs_pkg::RATIO_W-1:0]        o_shape_ratio,
    output wbs_pkg::t_shape_class              o_shape_class,
    output logic                               o_flat_signal
);

    // configuration
    logic [wbs_pkg::LEN_W-1:0]    r_batch_len;
    logic [wbs_pkg::TARGET_W-1:0] r_margin;
    logic [wbs_pkg::TARGET_W-1:0] r_tri_target;
    logic [wbs_pkg::TARGET_W-1:0] r_sine_target;
    logic [wbs_pkg::TARGET_W-1:0] r_rect_target;
    logic [wbs_pkg::LEN_W-1:0]    len_eff;

    // accumulators
    logic [wbs_pkg::SUM_W-1:0]       r_sum;
    logic [wbs_pkg::SQ_W-1:0]        r_sq;
    logic [wbs_pkg::SAMPLE_BITS-1:0] r_min;
    logic [wbs_pkg::SAMPLE_BITS-1:0] r_max;
    logic [wbs_pkg::CNT_W-1:0]       r_count;
    logic [wbs_pkg::SAMPLE_BITS-1:0] r_prev_mean;
    logic [wbs_pkg::CNT_W-1:0]       n_count;
    logic [wbs_pkg::SAMPLE_BITS-1:0] abs_diff;
    logic [wbs_pkg::SQR_W-1:0]       sq;

    // half range squared
    logic [wbs_pkg::SAMPLE_BITS-1:0] range_w;
    logic [wbs_pkg::HALF_W-1:0]      half;
    logic [wbs_pkg::DIVR_W-1:0]      r_half_sq;

    // divider
    logic                          r_busy;
    logic [wbs_pkg::STEP_W-1:0]    r_step;
    logic [wbs_pkg::DVD_W-1:0]     r_quo;
    logic [wbs_pkg::DVS_W-1:0]     r_rem;
    logic [wbs_pkg::DVS_W-1:0]     r_dvs;
    wbs_pkg::t_div_sel             r_sel;
    logic [wbs_pkg::DVD_W-1:0]     start_dvd;
    logic [wbs_pkg::DVS_W-1:0]     start_dvs;
    logic [wbs_pkg::DVS_W:0]       rem_sh;
    logic [wbs_pkg::DVS_W:0]       rem_sub;
    logic                          q_bit;
    logic [wbs_pkg::DVS_W-1:0]     n_rem;
    logic [wbs_pkg::DVD_W-1:0]     n_quo;
    logic                          div_done;

    // division results
    logic [wbs_pkg::SAMPLE_BITS-1:0] r_mean;
    logic [wbs_pkg::SQ_W-1:0]        r_msq;
    logic [wbs_pkg::SCALED_W-1:0]    r_scaled;
    logic [wbs_pkg::SCALED_W-1:0]    msq_ext;
    logic [wbs_pkg::RATIO_W-1:0]     r_ratio;
    wbs_pkg::t_shape_class           cls;
    logic                            flat;

    localparam logic [wbs_pkg::STEP_W-1:0] DIV_LAST_STEP =
        wbs_pkg::STEP_W'(wbs_pkg::DVD_W - 1);

    function automatic logic near_target(
        input logic [wbs_pkg::RATIO_W-1:0]  ratio,
        input logic [wbs_pkg::TARGET_W-1:0] target,
        input logic [wbs_pkg::TARGET_W-1:0] margin
    );
        logic [wbs_pkg::TARGET_W-1:0] lo;
        logic [wbs_pkg::TARGET_W:0]   hi;
        lo = (target > margin) ? (target - margin) : '0;
        hi = {1'b0, target} + {1'b0, margin};
        return (ratio >= lo) && ({1'b0, ratio} <= hi);
    endfunction

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_batch_len   <= wbs_pkg::RST_BATCH_LEN;
            r_margin      <= wbs_pkg::RST_MARGIN;
            r_tri_target  <= wbs_pkg::RST_TRI_TARGET;
            r_sine_target <= wbs_pkg::RST_SINE_TARGET;
            r_rect_target <= wbs_pkg::RST_RECT_TARGET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                wbs_pkg::REG_BATCH_LEN:    r_batch_len   <= i_cfg_wdata[wbs_pkg::LEN_W-1:0];
                wbs_pkg::REG_CLASS_MARGIN: r_margin      <= i_cfg_wdata[wbs_pkg::TARGET_W-1:0];
                wbs_pkg::REG_TRI_TARGET:   r_tri_target  <= i_cfg_wdata[wbs_pkg::TARGET_W-1:0];
                wbs_pkg::REG_SINE_TARGET:  r_sine_target <= i_cfg_wdata[wbs_pkg::TARGET_W-1:0];
                wbs_pkg::REG_RECT_TARGET:  r_rect_target <= i_cfg_wdata[wbs_pkg::TARGET_W-1:0];
                default: ;
            endcase
        end
    end

    // zero length acts as one, long lengths saturate
    always_comb begin
        priority if (r_batch_len == '0) begin
            len_eff = wbs_pkg::LEN_W'(1);
        end else if (r_batch_len > wbs_pkg::MAX_BATCH_LEN) begin
            len_eff = wbs_pkg::MAX_BATCH_LEN;
        end else begin
            len_eff = r_batch_len;
        end
    end

    assign n_count  = r_count + wbs_pkg::CNT_W'(1);
    assign abs_diff = (i_sample >= r_prev_mean) ? (i_sample - r_prev_mean)
                                                : (r_prev_mean - i_sample);
    assign sq       = wbs_pkg::SQR_W'(abs_diff) * wbs_pkg::SQR_W'(abs_diff);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum       <= '0;
            r_sq        <= '0;
            r_min       <= '1;
            r_max       <= '0;
            r_count     <= '0;
            r_prev_mean <= '0;
        end else if (i_cmd.accum) begin
            r_sum   <= r_sum + wbs_pkg::SUM_W'(i_sample);
            r_sq    <= r_sq + wbs_pkg::SQ_W'(sq);
            r_count <= n_count;
            if (i_sample < r_min) begin
                r_min <= i_sample;
            end
            if (i_sample > r_max) begin
                r_max <= i_sample;
            end
        end else if (i_cmd.out_load) begin
            r_prev_mean <= r_mean;
            r_sum       <= '0;
            r_sq        <= '0;
            r_min       <= '1;
            r_max       <= '0;
            r_count     <= '0;
        end
    end

    assign range_w = r_max - r_min;
    assign half    = range_w[wbs_pkg::SAMPLE_BITS-1:1];

    always_ff @(posedge i_clk) begin
        r_half_sq <= wbs_pkg::DIVR_W'(half) * wbs_pkg::DIVR_W'(half);
    end

    // operand select for the shared divider
    always_comb begin
        unique case (i_cmd.div_sel)
            wbs_pkg::DSEL_MSQ: begin
                start_dvd = wbs_pkg::DVD_W'(r_sq);
                start_dvs = wbs_pkg::DVS_W'(len_eff);
            end
            wbs_pkg::DSEL_RATIO: begin
                start_dvd = r_scaled;
                start_dvs = wbs_pkg::DVS_W'(r_half_sq);
            end
            default: begin
                start_dvd = wbs_pkg::DVD_W'(r_sum);
                start_dvs = wbs_pkg::DVS_W'(len_eff);
            end
        endcase
    end

    // one quotient bit per cycle, msb first
    assign rem_sh   = {r_rem, r_quo[wbs_pkg::DVD_W-1]};
    assign rem_sub  = rem_sh - {1'b0, r_dvs};
    assign q_bit    = (rem_sh >= {1'b0, r_dvs});
    assign n_rem    = q_bit ? rem_sub[wbs_pkg::DVS_W-1:0] : rem_sh[wbs_pkg::DVS_W-1:0];
    assign n_quo    = {r_quo[wbs_pkg::DVD_W-2:0], q_bit};
    assign div_done = r_busy && (r_step == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (i_cmd.div_start) begin
            r_busy <= 1'b1;
            r_step <= DIV_LAST_STEP;
            r_quo  <= start_dvd;
            r_rem  <= '0;
            r_dvs  <= start_dvs;
            r_sel  <= i_cmd.div_sel;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
            if (div_done) begin
                r_busy <= 1'b0;
                unique case (r_sel)
                    wbs_pkg::DSEL_MSQ:   r_msq   <= n_quo[wbs_pkg::SQ_W-1:0];
                    wbs_pkg::DSEL_RATIO: r_ratio <= n_quo[wbs_pkg::RATIO_W-1:0];
                    default:             r_mean  <= n_quo[wbs_pkg::SAMPLE_BITS-1:0];
                endcase
            end else begin
                r_step <= r_step - wbs_pkg::STEP_W'(1);
            end
        end
    end

    // scale by 1000 in two subtract steps
    assign msq_ext = wbs_pkg::SCALED_W'(r_msq);

    always_ff @(posedge i_clk) begin
        if (i_cmd.scale_hi) begin
            r_scaled <= (msq_ext << wbs_pkg::SCALE_SHIFT) - (msq_ext << wbs_pkg::SCALE_SUB_A);
        end else if (i_cmd.scale_lo) begin
            r_scaled <= r_scaled - (msq_ext << wbs_pkg::SCALE_SUB_B);
        end
    end

    assign flat = (r_half_sq == '0);

    always_comb begin
        priority if (near_target(r_ratio, r_tri_target, r_margin)) begin
            cls = wbs_pkg::CLS_TRIANGLE;
        end else if (near_target(r_ratio, r_sine_target, r_margin)) begin
            cls = wbs_pkg::CLS_SINE;
        end else if (near_target(r_ratio, r_rect_target, r_margin)) begin
            cls = wbs_pkg::CLS_RECT;
        end else begin
            cls = wbs_pkg::CLS_NONE;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_batch_min   <= r_min;
            o_batch_max   <= r_max;
            o_batch_mean  <= r_mean;
            o_flat_signal <= flat;
            o_shape_ratio <= flat ? '0 : r_ratio;
            o_shape_class <= flat ? wbs_pkg::CLS_NONE : cls;
        end
    end

    assign o_sts.batch_end = (n_count >= len_eff);
    assign o_sts.div_done  = div_done;
    assign o_sts.flat      = flat;

endmodule

`default_nettype wire

FILE: hw/rtl/waveform_batch_statistics.sv
// mid-batch: each sample transfer is accumulated and ready stays high
// batch end: the transfer that closes a batch starts three 58-step passes of
//          one shared divider (two for a flat batch) before its result shows
// throughput: 1 sample per cycle inside a batch; ready is low while the
//          end-of-batch divisions run, the result register frees the input side
// reset: synchronous active-low i_rst_n restores register defaults, clears all
//          accumulators and the previous mean, and empties the result register
// ----------------------------------------------------------------------------
// waveform_batch_statistics
// per-batch min, max, mean and shape ratio of converter samples, with a class
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module waveform_batch_statistics (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    wbs_sample_if.sink                      i_sample_ch,
    wbs_result_if.source                    o_result_ch,
    input  wire                             i_cfg_we,
    input  wire [wbs_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire [wbs_pkg::CFG_W-1:0]        i_cfg_wdata
);

    // command and status between sequencer and datapath
    wbs_pkg::t_dp_cmd cmd;
    wbs_pkg::t_dp_sts sts;

    // sequencer: holds input ready, result valid and the division order
    // (mean, mean square, then scaled ratio unless the batch is flat)
    wbs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_sample_ch.valid),
        .o_in_ready  (i_sample_ch.ready),
        .o_out_valid (o_result_ch.valid),
        .i_out_ready (o_result_ch.ready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    // datapath: accumulates each transfer as it is accepted, runs the shared
    // restoring divider and holds the result payload until its transfer
    wbs_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_sample      (i_sample_ch.sample),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_batch_min   (o_result_ch.batch_min),
        .o_batch_max   (o_result_ch.batch_max),
        .o_batch_mean  (o_result_ch.batch_mean),
        .o_shape_ratio (o_result_ch.shape_ratio),
        .o_shape_class (o_result_ch.shape_class),
        .o_flat_signal (o_result_ch.flat_signal)
    );

endmodule

`default_nettype wire

FILE: hw/rtl/wbs_checker.sv
// ----------------------------------------------------------------------------
// wbs_checker
// port-level assertions for the batch statistics block, bound to the top
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "waveform_batch_statistics_macros.svh"

module wbs_checker (
    input wire                              i_clk,
    input wire                              i_rst_n,
    input wire                              i_in_ready,
    input wire                              i_out_valid,
    input wire                              i_out_ready,
    input wire [wbs_pkg::SAMPLE_BITS-1:0]   i_batch_min,
    input wire [wbs_pkg::SAMPLE_BITS-1:0]   i_batch_max,
    input wire [wbs_pkg::SAMPLE_BITS-1:0]   i_batch_mean,
    input wire [wbs_pkg::RATIO_W-1:0]       i_shape_ratio,
    input wire [1:0]                        i_shape_class,
    input wire                              i_flat_signal
);

    // no result left over from before reset
    `WBS_ASSERT_RESET(a_rst_out_empty, i_clk, i_rst_n, !i_out_valid)

    // stalled result keeps its payload
    `WBS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_batch_min) && $stable(i_batch_max) && $stable(i_batch_mean) && $stable(i_shape_ratio) && $stable(i_shape_class) && $stable(i_flat_signal))

    // flat batch forces ratio and class to zero
    `WBS_ASSERT_IMPL(a_flat_zero, i_clk, i_rst_n, i_out_valid && i_flat_signal, (i_shape_ratio == '0) && (i_shape_class == wbs_pkg::CLS_NONE))

    // minimum never exceeds maximum: every batch holds at least one sample
    `WBS_ASSERT_IMPL(a_min_le_max, i_clk, i_rst_n, i_out_valid, i_batch_min <= i_batch_max)

    // a new result only appears after the end-of-batch work held input off
    `WBS_ASSERT_IMPL(a_result_after_busy, i_clk, i_rst_n, $rose(i_out_valid), !$past(i_in_ready))

endmodule

bind waveform_batch_statistics wbs_checker u_wbs_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_ready    (i_sample_ch.ready),
    .i_out_valid   (o_result_ch.valid),
    .i_out_ready   (o_result_ch.ready),
    .i_batch_min   (o_result_ch.batch_min),
    .i_batch_max   (o_result_ch.batch_max),
    .i_batch_mean  (o_result_ch.batch_mean),
    .i_shape_ratio (o_result_ch.shape_ratio),
    .i_shape_class (o_result_ch.shape_class),
    .i_flat_signal (o_result_ch.flat_signal)
);

`default_nettype wire

FILE: verif/waveform_batch_statistics_tb.sv
// ----------------------------------------------------------------------------
// waveform_batch_statistics_tb
// self-checking bench: a directed table of edge cases, then random waveform
// phases with idling and stalls, each result checked against hand-typed values or a local model
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module waveform_batch_statistics_tb;

    import wbs_pkg::*;

    localparam int  SAMPLE_MAX      = (1 << SAMPLE_BITS) - 1;
    localparam int  CFG_ALL_ONES    = (1 << CFG_W) - 1;
    localparam int  TARGET_MAX      = (1 << TARGET_W) - 1;
    localparam int  RATIO_SCALE     = 1000;
    localparam int  SETTLE_CYCLES   = 200;
    localparam int  DRAIN_CYCLES    = 200;
    localparam int  HOLD_OFF_CYCLES = 1500;
    localparam int  RANDOM_ITEMS    = 500;
    localparam int  RANDOM_RESULTS  = 40;
    localparam int  PHASE_ITEMS     = 64;
    localparam int  CYCLE_LIMIT     = 1_000_000;
    localparam real TWO_PI          = 6.283185307179586;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] batch_min;
        logic [SAMPLE_BITS-1:0] batch_max;
        logic [SAMPLE_BITS-1:0] batch_mean;
        logic [RATIO_W-1:0]     shape_ratio;
        t_shape_class           shape_class;
        logic                   flat_signal;
    } t_stats_result;

    typedef enum logic { STEP_WRITE, STEP_SAMPLE } t_step_kind;

    // one row of the directed table
    typedef struct packed {
        t_step_kind           kind;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [CFG_W-1:0]     value;
        logic                 checked;
        t_stats_result        known_stats;
    } t_step;

    typedef enum logic [1:0] { IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH } t_idle_mode;
    typedef enum logic [1:0] { WAVE_TRIANGLE, WAVE_SINE, WAVE_RECT, WAVE_NOISE } t_wave;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0]     cfg_wdata;

    wbs_sample_if sample_ch ();
    wbs_result_if result_ch ();

    waveform_batch_statistics DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_sample_ch (sample_ch),
        .o_result_ch (result_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata)
    );

    // local copy of the register file
    logic [LEN_W-1:0]       set_len;
    logic [TARGET_W-1:0]    set_margin;
    logic [TARGET_W-1:0]    set_tri;
    logic [TARGET_W-1:0]    set_sine;
    logic [TARGET_W-1:0]    set_rect;

    // local copy of the batch accumulators
    logic [SUM_W-1:0]       acc_sum;
    logic [SQ_W-1:0]        acc_sq;
    logic [SAMPLE_BITS-1:0] acc_min;
    logic [SAMPLE_BITS-1:0] acc_max;
    logic [CNT_W-1:0]       acc_count;
    logic [SAMPLE_BITS-1:0] last_mean;

    t_stats_result expected_stats[$];
    t_stats_result seen_stats;
    t_stats_result oldest_stats;

    int fail_count         = 0;
    int results_seen       = 0;
    int cycle_count        = 0;
    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int hold_off_asked     = 0;
    int hold_off_taken     = 0;
    int hold_left          = 0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void clear_batch();
        acc_sum   = '0;
        acc_sq    = '0;
        acc_min   = '1;
        acc_max   = '0;
        acc_count = '0;
    endfunction

    // class window: lower bound floors at zero, upper bound never wraps
    function automatic bit in_window(input logic [RATIO_W-1:0] ratio,
                                     input logic [TARGET_W-1:0] tgt);
        int lo;
        int hi;
        lo = (tgt > set_margin) ? int'(tgt) - int'(set_margin) : 0;
        hi = int'(tgt) + int'(set_margin);
        return (int'(ratio) >= lo) && (int'(ratio) <= hi);
    endfunction

    // folds one sample into the batch; returns 1 when it closes the batch
    function automatic bit fold_sample(input logic [SAMPLE_BITS-1:0] value,
                                       output t_stats_result stats);
        logic [LEN_W-1:0]       eff_len;
        logic [SAMPLE_BITS-1:0] half_span;
        logic [SAMPLE_BITS-1:0] mean;
        logic [63:0]            mean_sq;
        logic [63:0]            span_sq;
        int                     dev;
        eff_len = set_len;
        if (eff_len == '0) eff_len = LEN_W'(1);
        if (eff_len > MAX_BATCH_LEN) eff_len = MAX_BATCH_LEN;
        stats = '0;

        acc_sum = acc_sum + SUM_W'(value);
        dev     = int'(value) - int'(last_mean);
        acc_sq  = acc_sq + SQ_W'(dev * dev);
        if (value < acc_min) acc_min = value;
        if (value > acc_max) acc_max = value;
        acc_count = acc_count + 1'b1;
        if (acc_count < eff_len) return 1'b0;

        mean      = SAMPLE_BITS'(acc_sum / SUM_W'(eff_len));
        mean_sq   = 64'(acc_sq) / 64'(eff_len);
        half_span = (acc_max - acc_min) >> 1;
        span_sq   = 64'(half_span) * 64'(half_span);

        stats.batch_min   = acc_min;
        stats.batch_max   = acc_max;
        stats.batch_mean  = mean;
        stats.shape_class = CLS_NONE;
        if (span_sq == '0) begin
            // flat batch: ratio and class stay at zero
            stats.flat_signal = 1'b1;
        end else begin
            stats.shape_ratio = RATIO_W'((64'(RATIO_SCALE) * mean_sq) / span_sq);
            if (in_window(stats.shape_ratio, set_tri)) begin
                stats.shape_class = CLS_TRIANGLE;
            end else if (in_window(stats.shape_ratio, set_sine)) begin
                stats.shape_class = CLS_SINE;
            end else if (in_window(stats.shape_ratio, set_rect)) begin
                stats.shape_class = CLS_RECT;
            end
        end
        last_mean = mean;
        clear_batch();
        return 1'b1;
    endfunction

    function automatic t_step step_write(input logic [CFG_IDX_W-1:0] idx, input int value);
        t_step row;
        row         = '0;
        row.kind    = STEP_WRITE;
        row.reg_idx = idx;
        row.value   = CFG_W'(value);
        return row;
    endfunction

    function automatic t_step step_sample(input int value);
        t_step row;
        row       = '0;
        row.kind  = STEP_SAMPLE;
        row.value = CFG_W'(value);
        return row;
    endfunction

    // sample row whose result is typed in by hand
    function automatic t_step step_known(input int value, input int mn, input int mx,
                                         input int mean, input int ratio,
                                         input t_shape_class cls, input logic flat);
        t_step row;
        row                         = step_sample(value);
        row.checked                 = 1'b1;
        row.known_stats.batch_min   = SAMPLE_BITS'(mn);
        row.known_stats.batch_max   = SAMPLE_BITS'(mx);
        row.known_stats.batch_mean  = SAMPLE_BITS'(mean);
        row.known_stats.shape_ratio = RATIO_W'(ratio);
        row.known_stats.shape_class = cls;
        row.known_stats.flat_signal = flat;
        return row;
    endfunction

    // mostly the reset value, sometimes an extreme or anything at all
    function automatic int pick_setting(input int reset_value);
        case ($urandom_range(9))
            0:       return 0;
            1:       return TARGET_MAX;
            2:       return $urandom_range(TARGET_MAX);
            default: return reset_value;
        endcase
    endfunction

    // block idle: all results in, then a quiet settling wait
    task automatic settle();
        sample_ch.valid <= 1'b0;
        do @(posedge clk); while (expected_stats.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // leaves the write enable high so that writes can follow back to back
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        case (idx)
            REG_BATCH_LEN:    set_len    = LEN_W'(data);
            REG_CLASS_MARGIN: set_margin = TARGET_W'(data);
            REG_TRI_TARGET:   set_tri    = TARGET_W'(data);
            REG_SINE_TARGET:  set_sine   = TARGET_W'(data);
            REG_RECT_TARGET:  set_rect   = TARGET_W'(data);
            default: ;
        endcase
    endtask

    // one sample transfer, with random sender gaps ahead of it
    task automatic send_sample(input logic [SAMPLE_BITS-1:0] value, input logic checked,
                               input t_stats_result known);
        t_stats_result stats;
        while ($urandom_range(99) < sender_idle_pct) begin
            sample_ch.valid <= 1'b0;
            @(posedge clk);
        end
        sample_ch.valid  <= 1'b1;
        sample_ch.sample <= value;
        do @(posedge clk); while (!sample_ch.ready);
        if (fold_sample(value, stats) && !checked) expected_stats.push_back(stats);
        if (checked) expected_stats.push_back(known);
    endtask

    task automatic compare_field(input string field, input int unsigned want,
                                 input int unsigned got);
        if (want != got) begin
            $display("%0t ns: %s expected %0d actual %0d", $time, field, want, got);
            fail_count++;
        end
    endtask

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge clk) begin
        if (!rst_n) begin
            result_ch.ready <= 1'b0;
        end else if (hold_off_taken != hold_off_asked) begin
            hold_off_taken = hold_off_asked;
            hold_left      = HOLD_OFF_CYCLES;
            result_ch.ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left = hold_left - 1;
            result_ch.ready <= 1'b0;
        end else begin
            result_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // result transfers checked in order against the oldest expectation
    always @(posedge clk) begin
        if (rst_n && result_ch.valid && result_ch.ready) begin
            seen_stats.batch_min   = result_ch.batch_min;
            seen_stats.batch_max   = result_ch.batch_max;
            seen_stats.batch_mean  = result_ch.batch_mean;
            seen_stats.shape_ratio = result_ch.shape_ratio;
            seen_stats.shape_class = result_ch.shape_class;
            seen_stats.flat_signal = result_ch.flat_signal;
            results_seen++;
            if (expected_stats.size() == 0) begin
                $display("%0t ns: result with none expected, actual %h", $time, seen_stats);
                fail_count++;
            end else begin
                oldest_stats = expected_stats.pop_front();
                compare_field("batch_min", oldest_stats.batch_min, seen_stats.batch_min);
                compare_field("batch_max", oldest_stats.batch_max, seen_stats.batch_max);
                compare_field("batch_mean", oldest_stats.batch_mean, seen_stats.batch_mean);
                compare_field("shape_ratio", oldest_stats.shape_ratio,
                              seen_stats.shape_ratio);
                compare_field("shape_class", oldest_stats.shape_class,
                              seen_stats.shape_class);
                compare_field("flat_signal", oldest_stats.flat_signal,
                              seen_stats.flat_signal);
            end
        end
    end

    // watchdog
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAIL waveform_batch_statistics");
            $finish;
        end
    end

    initial begin : stimulus
        t_step      directed_steps[$];
        t_wave      kind;
        t_idle_mode mode;
        bit         writing;
        int         phase;
        int         period;
        int         len;
        int         amp;
        int         centre;
        int         level;
        int         random_items;

        // known values on the sender side from time zero
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_idx            = REG_BATCH_LEN;
        cfg_wdata          = '0;
        sample_ch.valid    = 1'b0;
        sample_ch.sample   = '0;
        set_len            = RST_BATCH_LEN;
        set_margin         = RST_MARGIN;
        set_tri            = RST_TRI_TARGET;
        set_sine           = RST_SINE_TARGET;
        set_rect           = RST_RECT_TARGET;
        last_mean          = '0;
        clear_batch();
        writing            = 1'b0;
        random_items       = 0;

        // single-sample batches: flat at both ends of the range
        directed_steps.push_back(step_write(REG_BATCH_LEN, 1));
        directed_steps.push_back(step_known(0, 0, 0, 0, 0, CLS_NONE, 1'b1));
        directed_steps.push_back(step_known(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX,
                                            0, CLS_NONE, 1'b1));
        directed_steps.push_back(step_known(0, 0, 0, 0, 0, CLS_NONE, 1'b1));
        // full swing from a zero mean lands outside every class
        directed_steps.push_back(step_write(REG_BATCH_LEN, 2));
        directed_steps.push_back(step_sample(0));
        directed_steps.push_back(step_known(SAMPLE_MAX, 0, SAMPLE_MAX, 2047, 2000,
                                            CLS_NONE, 1'b0));
        // square swing about the previous mean is a rectangle
        directed_steps.push_back(step_sample(1047));
        directed_steps.push_back(step_known(3047, 1047, 3047, 2047, 1000, CLS_RECT, 1'b0));
        // half the batch on the mean reads as a sine
        directed_steps.push_back(step_write(REG_BATCH_LEN, 4));
        directed_steps.push_back(step_sample(1047));
        directed_steps.push_back(step_sample(3047));
        directed_steps.push_back(step_sample(2047));
        directed_steps.push_back(step_sample(2047));
        // two thirds on the mean reads as a triangle
        directed_steps.push_back(step_write(REG_BATCH_LEN, 6));
        directed_steps.push_back(step_sample(1047));
        directed_steps.push_back(step_sample(3047));
        repeat (4) directed_steps.push_back(step_sample(2047));
        // widest margin, target under the margin, extreme targets
        directed_steps.push_back(step_write(REG_CLASS_MARGIN, TARGET_MAX));
        directed_steps.push_back(step_write(REG_TRI_TARGET, 0));
        directed_steps.push_back(step_write(REG_SINE_TARGET, TARGET_MAX));
        directed_steps.push_back(step_write(REG_RECT_TARGET, 0));
        directed_steps.push_back(step_write(REG_BATCH_LEN, 2));
        directed_steps.push_back(step_sample(SAMPLE_MAX));
        directed_steps.push_back(step_sample(0));
        // zero margin, hit exactly on the rectangle target
        directed_steps.push_back(step_write(REG_CLASS_MARGIN, 0));
        directed_steps.push_back(step_write(REG_TRI_TARGET, TARGET_MAX));
        directed_steps.push_back(step_write(REG_SINE_TARGET, 0));
        directed_steps.push_back(step_write(REG_RECT_TARGET, RST_RECT_TARGET));
        directed_steps.push_back(step_sample(1047));
        directed_steps.push_back(step_sample(3047));
        // longest batch, then oversize length, unmapped indexes, zero length mid batch
        directed_steps.push_back(step_write(REG_BATCH_LEN, MAX_BATCH_LEN));
        directed_steps.push_back(step_sample(5));
        directed_steps.push_back(step_sample(4000));
        directed_steps.push_back(step_write(REG_BATCH_LEN, CFG_ALL_ONES));
        directed_steps.push_back(step_sample(100));
        for (int idx = REG_RECT_TARGET + 1; idx < (1 << CFG_IDX_W); idx++) begin
            directed_steps.push_back(step_write(CFG_IDX_W'(idx), CFG_ALL_ONES));
        end
        directed_steps.push_back(step_write(REG_BATCH_LEN, 0));
        directed_steps.push_back(step_sample(2000));

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // directed table, no idling
        foreach (directed_steps[i]) begin
            if (directed_steps[i].kind == STEP_WRITE) begin
                if (!writing) settle();
                write_reg(directed_steps[i].reg_idx, directed_steps[i].value);
                writing = 1'b1;
            end else begin
                if (writing) cfg_we <= 1'b0;
                writing = 1'b0;
                send_sample(SAMPLE_BITS'(directed_steps[i].value), directed_steps[i].checked,
                            directed_steps[i].known_stats);
            end
        end

        // random phases: mostly whole periods per batch so the class targets are reachable
        for (phase = 0; random_items < RANDOM_ITEMS || results_seen < RANDOM_RESULTS;
             phase++) begin
            period = 2 * $urandom_range(2, 6);
            len    = ($urandom_range(4) == 0) ? $urandom_range(1, 24)
                                              : period * $urandom_range(1, 2);
            settle();
            if ($urandom_range(5) == 0) begin
                write_reg(CFG_IDX_W'($urandom_range(REG_RECT_TARGET + 1, (1 << CFG_IDX_W) - 1)),
                          CFG_W'($urandom));
            end
            write_reg(REG_BATCH_LEN, CFG_W'(len));
            write_reg(REG_CLASS_MARGIN, CFG_W'(pick_setting(RST_MARGIN)));
            write_reg(REG_TRI_TARGET, CFG_W'(pick_setting(RST_TRI_TARGET)));
            write_reg(REG_SINE_TARGET, CFG_W'(pick_setting(RST_SINE_TARGET)));
            write_reg(REG_RECT_TARGET, CFG_W'(pick_setting(RST_RECT_TARGET)));
            cfg_we <= 1'b0;

            mode = t_idle_mode'(phase % 4);
            case (mode)
                IDLE_NONE:     begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                IDLE_SENDER:   begin sender_idle_pct = 77; receiver_stall_pct = 0;  end
                IDLE_RECEIVER: begin sender_idle_pct = 0;  receiver_stall_pct = 77; end
                default:       begin sender_idle_pct = 12; receiver_stall_pct = 12; end
            endcase
            // first phase: receiver holds off so results back up and the input stalls
            if (phase == 0) hold_off_asked++;

            kind   = t_wave'($urandom_range(3));
            amp    = $urandom_range(1, SAMPLE_MAX / 2);
            centre = amp + $urandom_range(0, SAMPLE_MAX - 2 * amp);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // second phase: sender pauses midway until the results drain
                if (phase == 1 && n == PHASE_ITEMS / 2) begin
                    sample_ch.valid <= 1'b0;
                    do @(posedge clk); while (expected_stats.size() != 0);
                end
                case (kind)
                    WAVE_TRIANGLE: begin
                        if (2 * (n % period) < period) begin
                            level = centre - amp + (4 * amp * (n % period)) / period;
                        end else begin
                            level = centre + 3 * amp - (4 * amp * (n % period)) / period;
                        end
                    end
                    WAVE_SINE: level = centre + $rtoi(amp * $sin(TWO_PI * n / period));
                    WAVE_RECT: level = (2 * (n % period) < period) ? centre + amp : centre - amp;
                    default:   level = $urandom_range(SAMPLE_MAX);
                endcase
                // occasional broken sample: a spike to either rail or anywhere
                if ($urandom_range(24) == 0) begin
                    case ($urandom_range(2))
                        0:       level = 0;
                        1:       level = SAMPLE_MAX;
                        default: level = $urandom_range(SAMPLE_MAX);
                    endcase
                end
                if (level < 0) level = 0;
                if (level > SAMPLE_MAX) level = SAMPLE_MAX;
                send_sample(SAMPLE_BITS'(level), 1'b0, '0);
                random_items++;
            end
        end

        // drain, then let the block go quiet
        sample_ch.valid <= 1'b0;
        do @(posedge clk); while (expected_stats.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0) begin
            $display("PASS waveform_batch_statistics");
        end else begin
            $display("FAIL waveform_batch_statistics");
        end
        $finish;
    end

endmodule

FILE: waveform_batch_statistics.f
+incdir+hw/rtl
hw/rtl/wbs_pkg.sv
hw/rtl/wbs_sample_if.sv
hw/rtl/wbs_result_if.sv
hw/rtl/wbs_ctrl.sv
hw/rtl/wbs_dpath.sv
hw/rtl/waveform_batch_statistics.sv
hw/rtl/wbs_checker.sv
verif/waveform_batch_statistics_tb.sv
